### rtl/bpnd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bpnd_pkg;

  // Coordinate width of every frame and preview dimension
  localparam int unsigned COORD_BITS = 14;
  localparam int unsigned CW         = COORD_BITS;
  // One quotient bit per divider step
  localparam int unsigned DIV_STEPS  = COORD_BITS;
  localparam int unsigned NUM_W      = 2 * COORD_BITS + 1;
  localparam int unsigned DEN_W      = COORD_BITS + 1;
  localparam int unsigned IDX_W      = 2 * COORD_BITS;
  localparam int unsigned CFG_IDX_W  = 3;
  // Input register, two dividers, two scale stages, four address stages
  localparam int unsigned PIPE_LAT   = 2 * DIV_STEPS + 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RAW_W   = 3'd0,
    CFG_RAW_H   = 3'd1,
    CFG_VIS_W   = 3'd2,
    CFG_VIS_H   = 3'd3,
    CFG_LEFT    = 3'd4,
    CFG_TOP     = 3'd5,
    CFG_PMAX    = 3'd6,
    CFG_USABLE  = 3'd7
  } cfg_reg_e;

  // Configuration and the values derived from it (the user must keep it static while items fly; not enforced)
  typedef struct packed {
    logic [CW-1:0] raw_w;
    logic [CW-1:0] raw_h;
    logic [CW-1:0] vw;
    logic [CW-1:0] vh;
    logic [CW-1:0] left;
    logic [CW-1:0] top;
    logic          ok_pre;
  } cfg_t;

  // Item data that travels alongside the dividers
  typedef struct packed {
    logic [CW-1:0] dx;
    logic [CW-1:0] dy;
    logic [CW-1:0] pw;
    logic [CW-1:0] ph;
    logic          ok;
    logic          x_over;
    logic          y_over;
  } side_t;

  // One divider lane: partial remainder, divisor, quotient so far
  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [CW-1:0]    quo;
  } div_lane_t;

endpackage
`default_nettype wire

### rtl/bayer_parity_nearest_downscale_addr.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Handshake                  Payload
// input     start_i, busy_o            dest_x_i, dest_y_i
// result    valid_o (one-cycle strobe) proxy_ok_o, preview_*_o, coord_in_range_o,
//                                      raw_col_o, raw_row_o, raw_index_o
// config    cfg_valid_i, cfg_ready_o   cfg_index_i, cfg_data_i
//
// One item per cycle; each item passes the input register, a 14-step
// divider, the scale stages, a second 14-step divider and the address stages.
// busy_o and cfg_ready_o are constant: the pipeline never stalls.
// rst_ni clears the valid chain and all configuration registers to zero.
// Results cannot be held off; the user must change configuration only while idle (the block does not enforce this).
module bayer_parity_nearest_downscale_addr import bpnd_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire logic [CW-1:0]        dest_x_i,
  input  wire logic [CW-1:0]        dest_y_i,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CW-1:0]        cfg_data_i,
  output logic                      valid_o,
  output logic                      proxy_ok_o,
  output logic [CW-1:0]             preview_width_o,
  output logic [CW-1:0]             preview_height_o,
  output logic                      coord_in_range_o,
  output logic [CW-1:0]             raw_col_o,
  output logic [CW-1:0]             raw_row_o,
  output logic [IDX_W-1:0]          raw_index_o
);

  logic [CW-1:0]   raw_w_q, raw_h_q, vis_w_q, vis_h_q, left_q, top_q, pmax_q;
  logic            usable_q;
  cfg_t            cfg;
  logic [CW-1:0]   longest;
  logic            accept;

  logic            s0_vld_q;
  div_lane_t [1:0] s0_lane_q, s0_lane_d;
  side_t           s0_side_q, s0_side_d;

  logic            d1_vld, mid_vld, d2_vld;
  div_lane_t [1:0] d1_lane, mid_lane, d2_lane;
  side_t           d1_side, mid_side, d2_side;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_w_q  <= '0;
      raw_h_q  <= '0;
      vis_w_q  <= '0;
      vis_h_q  <= '0;
      left_q   <= '0;
      top_q    <= '0;
      pmax_q   <= '0;
      usable_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_RAW_W:  raw_w_q  <= cfg_data_i;
        CFG_RAW_H:  raw_h_q  <= cfg_data_i;
        CFG_VIS_W:  vis_w_q  <= cfg_data_i;
        CFG_VIS_H:  vis_h_q  <= cfg_data_i;
        CFG_LEFT:   left_q   <= cfg_data_i;
        CFG_TOP:    top_q    <= cfg_data_i;
        CFG_PMAX:   pmax_q   <= cfg_data_i;
        CFG_USABLE: usable_q <= cfg_data_i[0];
        default:    ;
      endcase
    end
  end

  // Effective visible size and first proxy checks
  always_comb begin
    cfg.raw_w  = raw_w_q;
    cfg.raw_h  = raw_h_q;
    cfg.vw     = (vis_w_q != '0) ? vis_w_q : raw_w_q;
    cfg.vh     = (vis_h_q != '0) ? vis_h_q : raw_h_q;
    cfg.left   = left_q;
    cfg.top    = top_q;
    longest    = (cfg.vw > cfg.vh) ? cfg.vw : cfg.vh;
    cfg.ok_pre = usable_q && (pmax_q != '0) && (cfg.vw >= CW'(2)) &&
                 (cfg.vh >= CW'(2)) && (longest > pmax_q) &&
                 (raw_w_q != '0) && (raw_h_q != '0);
  end

  // Input register: rounded scale numerators v*pmax + L/2 over L
  always_comb begin
    s0_side_d    = '0;
    s0_side_d.dx = dest_x_i;
    s0_side_d.dy = dest_y_i;
    s0_lane_d[0].rem = NUM_W'(cfg.vw) * NUM_W'(pmax_q) + NUM_W'(longest >> 1);
    s0_lane_d[0].den = DEN_W'(longest);
    s0_lane_d[0].quo = '0;
    s0_lane_d[1].rem = NUM_W'(cfg.vh) * NUM_W'(pmax_q) + NUM_W'(longest >> 1);
    s0_lane_d[1].den = DEN_W'(longest);
    s0_lane_d[1].quo = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else begin
      s0_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_lane_q <= s0_lane_d;
    s0_side_q <= s0_side_d;
  end

  bpnd_div2 u_scale_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_vld_i   (s0_vld_q),
    .in_lane_i  (s0_lane_q),
    .in_side_i  (s0_side_q),
    .out_vld_o  (d1_vld),
    .out_lane_o (d1_lane),
    .out_side_o (d1_side)
  );

  bpnd_mid u_mid (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .vld_i  (d1_vld),
    .lane_i (d1_lane),
    .side_i (d1_side),
    .vld_o  (mid_vld),
    .lane_o (mid_lane),
    .side_o (mid_side)
  );

  bpnd_div2 u_map_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_vld_i   (mid_vld),
    .in_lane_i  (mid_lane),
    .in_side_i  (mid_side),
    .out_vld_o  (d2_vld),
    .out_lane_o (d2_lane),
    .out_side_o (d2_side)
  );

  bpnd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .vld_i            (d2_vld),
    .lane_i           (d2_lane),
    .side_i           (d2_side),
    .valid_o          (valid_o),
    .proxy_ok_o       (proxy_ok_o),
    .preview_width_o  (preview_width_o),
    .preview_height_o (preview_height_o),
    .coord_in_range_o (coord_in_range_o),
    .raw_col_o        (raw_col_o),
    .raw_row_o        (raw_row_o),
    .raw_index_o      (raw_index_o)
  );

  // Every accepted item yields its result after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##PIPE_LAT valid_o)
    else $error("result missing after pipeline latency");

  // No proxy means an all-zero result
  a_zero_when_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !proxy_ok_o) |-> (preview_width_o == '0 &&
      preview_height_o == '0 && raw_index_o == '0 && !coord_in_range_o))
    else $error("fields not cleared without proxy");

  // Preview sides are even and non-zero
  a_even_sides: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && proxy_ok_o) |-> (preview_width_o[0] == 1'b0 &&
      preview_height_o[0] == 1'b0 && preview_width_o != '0 &&
      preview_height_o != '0))
    else $error("preview size not even");

  // Selected sample lies inside the raw frame
  a_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && proxy_ok_o) |-> (raw_col_o < raw_w_q && raw_row_o < raw_h_q))
    else $error("raw position outside frame");

endmodule
`default_nettype wire

### rtl/bpnd_div2.sv
`timescale 1ns / 1ps
`default_nettype none
// Two-lane restoring divider, one quotient bit per register stage
module bpnd_div2 import bpnd_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_vld_i,
  input  wire div_lane_t [1:0] in_lane_i,
  input  wire side_t           in_side_i,
  output logic                 out_vld_o,
  output div_lane_t [1:0]      out_lane_o,
  output side_t                out_side_o
);

  logic            vld_q    [DIV_STEPS];
  div_lane_t [1:0] lane_q   [DIV_STEPS];
  side_t           side_q   [DIV_STEPS];
  logic            src_vld  [DIV_STEPS];
  div_lane_t [1:0] src_lane [DIV_STEPS];
  side_t           src_side [DIV_STEPS];
  div_lane_t [1:0] lane_d   [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    localparam int unsigned Bit = DIV_STEPS - 1 - k;

    // Stage input: module input or previous stage
    if (k == 0) begin : g_first
      assign src_vld[k]  = in_vld_i;
      assign src_lane[k] = in_lane_i;
      assign src_side[k] = in_side_i;
    end else begin : g_next
      assign src_vld[k]  = vld_q[k-1];
      assign src_lane[k] = lane_q[k-1];
      assign src_side[k] = side_q[k-1];
    end

    // Trial subtract of the shifted divisor
    always_comb begin
      logic [NUM_W-1:0] dsh;
      lane_d[k] = src_lane[k];
      for (int l = 0; l < 2; l++) begin
        dsh = NUM_W'(src_lane[k][l].den) << Bit;
        if (src_lane[k][l].rem >= dsh) begin
          lane_d[k][l].rem      = src_lane[k][l].rem - dsh;
          lane_d[k][l].quo[Bit] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= src_vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      lane_q[k] <= lane_d[k];
      side_q[k] <= src_side[k];
    end
  end

  assign out_vld_o  = vld_q[DIV_STEPS-1];
  assign out_lane_o = lane_q[DIV_STEPS-1];
  assign out_side_o = side_q[DIV_STEPS-1];

endmodule
`default_nettype wire

### rtl/bpnd_mid.sv
`timescale 1ns / 1ps
`default_nettype none
// Preview size fix-up, then numerators of the pixel-centre mapping
module bpnd_mid import bpnd_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire cfg_t            cfg_i,
  input  wire logic            vld_i,
  input  wire div_lane_t [1:0] lane_i,
  input  wire side_t           side_i,
  output logic                 vld_o,
  output div_lane_t [1:0]      lane_o,
  output side_t                side_o
);

  // Clamp to range and, when v is at least 2, force even
  function automatic logic [CW-1:0] fit_side(input logic [CW-1:0] s_raw,
                                             input logic [CW-1:0] v);
    logic [CW-1:0] s;
    s = s_raw;
    if (s < CW'(1)) s = CW'(1);
    if (s > v) s = v;
    if (v >= CW'(2)) begin
      if (s < CW'(2)) s = CW'(2);
      s[0] = 1'b0;
      if (s > v) s = {v[CW-1:1], 1'b0};
    end
    if (s < CW'(1)) s = CW'(1);
    return s;
  endfunction

  logic            m1_vld_q, m2_vld_q;
  side_t           m1_side_q, m1_side_d, m2_side_q, m2_side_d;
  div_lane_t [1:0] m2_lane_q, m2_lane_d;

  // Stage 1: preview sides and final proxy decision
  always_comb begin
    logic [CW-1:0] pw, ph;
    pw = fit_side(lane_i[0].quo, cfg_i.vw);
    ph = fit_side(lane_i[1].quo, cfg_i.vh);
    m1_side_d    = side_i;
    m1_side_d.pw = pw;
    m1_side_d.ph = ph;
    m1_side_d.ok = cfg_i.ok_pre && ((pw != cfg_i.vw) || (ph != cfg_i.vh));
  end

  // Stage 2: (2d+1)*S over 2D set up for the divider
  always_comb begin
    m2_side_d        = m1_side_q;
    m2_side_d.x_over = m1_side_q.dx >= m1_side_q.pw;
    m2_side_d.y_over = m1_side_q.dy >= m1_side_q.ph;
    m2_lane_d[0].rem = NUM_W'({m1_side_q.dx, 1'b1}) * NUM_W'(cfg_i.vw);
    m2_lane_d[0].den = {m1_side_q.pw, 1'b0};
    m2_lane_d[0].quo = '0;
    m2_lane_d[1].rem = NUM_W'({m1_side_q.dy, 1'b1}) * NUM_W'(cfg_i.vh);
    m2_lane_d[1].den = {m1_side_q.ph, 1'b0};
    m2_lane_d[1].quo = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_vld_q <= 1'b0;
      m2_vld_q <= 1'b0;
    end else begin
      m1_vld_q <= vld_i;
      m2_vld_q <= m1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m1_side_q <= m1_side_d;
    m2_side_q <= m2_side_d;
    m2_lane_q <= m2_lane_d;
  end

  assign vld_o  = m2_vld_q;
  assign lane_o = m2_lane_q;
  assign side_o = m2_side_q;

endmodule
`default_nettype wire

### rtl/bpnd_back.sv
`timescale 1ns / 1ps
`default_nettype none
// Clamp, Bayer parity step, crop offset, linear address
module bpnd_back import bpnd_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire cfg_t            cfg_i,
  input  wire logic            vld_i,
  input  wire div_lane_t [1:0] lane_i,
  input  wire side_t           side_i,
  output logic                 valid_o,
  output logic                 proxy_ok_o,
  output logic [CW-1:0]        preview_width_o,
  output logic [CW-1:0]        preview_height_o,
  output logic                 coord_in_range_o,
  output logic [CW-1:0]        raw_col_o,
  output logic [CW-1:0]        raw_row_o,
  output logic [IDX_W-1:0]     raw_index_o
);

  // Move by one to match the destination parity, lower neighbour first
  function automatic logic [CW-1:0] match_parity(input logic [CW-1:0] c,
                                                 input logic          d0,
                                                 input logic [CW-1:0] s);
    logic [CW-1:0] r;
    r = c;
    if (c[0] != d0) begin
      if (c != '0)            r = c - CW'(1);
      else if (CW'(1) < s)    r = c + CW'(1);
    end
    return r;
  endfunction

  // Add margin, clamp to the last raw position
  function automatic logic [CW-1:0] place(input logic [CW-1:0] m,
                                          input logic [CW-1:0] s,
                                          input logic [CW-1:0] rsize);
    logic [CW:0]   v;
    logic [CW-1:0] lim;
    v   = {1'b0, m} + {1'b0, s};
    lim = rsize - CW'(1);
    return (v > {1'b0, lim}) ? lim : v[CW-1:0];
  endfunction

  logic                 b1_vld_q, b2_vld_q, b3_vld_q, out_vld_q;
  side_t                b1_side_q, b2_side_q, b3_side_q;
  logic [CW-1:0]        b1_cx_q, b1_cy_q, b1_cx_d, b1_cy_d;
  logic [CW-1:0]        b2_col_q, b2_row_q, b3_col_q, b3_row_q;
  logic [IDX_W-1:0]     b3_prod_q;
  logic                 ok_q, in_range_q;
  logic [CW-1:0]        pw_q, ph_q, col_q, row_q;
  logic [IDX_W-1:0]     index_q;

  // Stage 1: clamp out-of-preview coordinates, then parity step
  always_comb begin
    logic [CW-1:0] cx, cy;
    cx = side_i.x_over ? (cfg_i.vw - CW'(1)) : lane_i[0].quo;
    cy = side_i.y_over ? (cfg_i.vh - CW'(1)) : lane_i[1].quo;
    b1_cx_d = match_parity(cx, side_i.dx[0], cfg_i.vw);
    b1_cy_d = match_parity(cy, side_i.dy[0], cfg_i.vh);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_vld_q  <= 1'b0;
      b2_vld_q  <= 1'b0;
      b3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      b1_vld_q  <= vld_i;
      b2_vld_q  <= b1_vld_q;
      b3_vld_q  <= b2_vld_q;
      out_vld_q <= b3_vld_q;
    end
  end

  // Stages 2 to 4: crop offset, row product, final sum and zeroing
  always_ff @(posedge clk_i) begin
    b1_side_q  <= side_i;
    b1_cx_q    <= b1_cx_d;
    b1_cy_q    <= b1_cy_d;
    b2_side_q  <= b1_side_q;
    b2_col_q   <= place(cfg_i.left, b1_cx_q, cfg_i.raw_w);
    b2_row_q   <= place(cfg_i.top, b1_cy_q, cfg_i.raw_h);
    b3_side_q  <= b2_side_q;
    b3_col_q   <= b2_col_q;
    b3_row_q   <= b2_row_q;
    b3_prod_q  <= IDX_W'(b2_row_q) * IDX_W'(cfg_i.raw_w);
    ok_q       <= b3_side_q.ok;
    pw_q       <= b3_side_q.ok ? b3_side_q.pw : '0;
    ph_q       <= b3_side_q.ok ? b3_side_q.ph : '0;
    in_range_q <= b3_side_q.ok && !b3_side_q.x_over && !b3_side_q.y_over;
    col_q      <= b3_side_q.ok ? b3_col_q : '0;
    row_q      <= b3_side_q.ok ? b3_row_q : '0;
    index_q    <= b3_side_q.ok ? (b3_prod_q + IDX_W'(b3_col_q)) : '0;
  end

  assign valid_o          = out_vld_q;
  assign proxy_ok_o       = ok_q;
  assign preview_width_o  = pw_q;
  assign preview_height_o = ph_q;
  assign coord_in_range_o = in_range_q;
  assign raw_col_o        = col_q;
  assign raw_row_o        = row_q;
  assign raw_index_o      = index_q;

endmodule
`default_nettype wire
